// ===== hdl/bgcd_pkg.sv =====
// Shared types and field widths for the binary GCD pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package bgcd_pkg;

  // Stream field widths (fixed by the interface)
  localparam int OPERAND_W = 32;
  localparam int DIVISOR_W = 32;
  localparam int S_TDATA_W = 2 * OPERAND_W;
  localparam int M_TDATA_W = DIVISOR_W;

  // Per-stage control travelling alongside the operands
  typedef struct packed {
    logic valid;  // stage holds a live item
    logic pre;    // still stripping the common power of two
  } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/binary_gcd_top.sv =====
// Binary GCD engine: operand pairs in, greatest common divisor out, one pair
// per cycle unless stalled. Depends on bgcd_pkg, bgcd_step and bgcd_out.
//
// Takes one operand pair per clock and returns its greatest common divisor
// (Stein's algorithm); when either operand is zero the result is the OR of
// the two. Operands are reduced to DATA_WIDTH bits first. The datapath is a
// fixed pipeline: one input register, 2*DATA_WIDTH+1 step stages (each does
// one shift or one subtract-and-halve, which bounds the worst case), then the
// output register; with no stall one beat can be accepted every cycle. A skid
// beat behind the output register keeps s_tready registered; back-pressure on
// the master side stops the whole pipeline.
`default_nettype none

module binary_gcd_top #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [bgcd_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] operand_a, [63:32] operand_b
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [bgcd_pkg::M_TDATA_W-1:0]    m_tdata    // [31:0] divisor
);
  import bgcd_pkg::*;

  localparam int TWOS_W    = $clog2(DATA_WIDTH);
  localparam int NUM_STEPS = 2 * DATA_WIDTH + 1;

  ctl_t                  ctl  [NUM_STEPS+1];
  logic [DATA_WIDTH-1:0] a_st [NUM_STEPS+1];
  logic [DATA_WIDTH-1:0] b_st [NUM_STEPS+1];
  logic [TWOS_W-1:0]     twos_st [NUM_STEPS+1];

  logic                          en;
  logic                          skid_valid;
  logic [DATA_WIDTH+OPERAND_W-1:0] a_ext;
  logic [DATA_WIDTH+OPERAND_W-1:0] b_ext;
  logic [DATA_WIDTH-1:0]         a_in;
  logic [DATA_WIDTH-1:0]         b_in;
  logic                          any_zero;

  assign a_ext    = {{DATA_WIDTH{1'b0}}, s_tdata[OPERAND_W-1:0]};
  assign b_ext    = {{DATA_WIDTH{1'b0}}, s_tdata[S_TDATA_W-1:OPERAND_W]};
  assign a_in     = a_ext[DATA_WIDTH-1:0];
  assign b_in     = b_ext[DATA_WIDTH-1:0];
  assign any_zero = (a_in == '0) || (b_in == '0);
  assign s_tready = en;

  // Entry stage: a zero operand finishes at once as a|b with b cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0] <= '0;
    end else if (en) begin
      ctl[0].valid <= s_tvalid;
      ctl[0].pre   <= !any_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_st[0]    <= any_zero ? (a_in | b_in) : a_in;
      b_st[0]    <= any_zero ? '0 : b_in;
      twos_st[0] <= '0;
    end
  end

  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    bgcd_step #(
      .DATA_WIDTH (DATA_WIDTH),
      .TWOS_W     (TWOS_W)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (ctl[i]),
      .a_in     (a_st[i]),
      .b_in     (b_st[i]),
      .twos_in  (twos_st[i]),
      .ctl_out  (ctl[i+1]),
      .a_out    (a_st[i+1]),
      .b_out    (b_st[i+1]),
      .twos_out (twos_st[i+1])
    );
  end

  bgcd_out #(
    .DATA_WIDTH (DATA_WIDTH),
    .TWOS_W     (TWOS_W)
  ) u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (ctl[NUM_STEPS].valid),
    .a_in       (a_st[NUM_STEPS]),
    .twos_in    (twos_st[NUM_STEPS]),
    .en         (en),
    .skid_valid (skid_valid),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // Every item must have converged by the last step stage
  assert property (@(posedge clk) disable iff (rst)
    ctl[NUM_STEPS].valid |-> (!ctl[NUM_STEPS].pre && b_st[NUM_STEPS] == '0))
    else $error("gcd item left the step pipeline unfinished");

  // A parked beat always sits behind a presented one
  assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid beat held with no output beat");

  // The input side only closes after the output was held
  assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(m_tvalid && !m_tready))
    else $error("s_tready dropped without a stalled output");

  // A parked beat moves to the output on the next taken beat
  assert property (@(posedge clk) disable iff (rst)
    skid_valid && m_tready |=> m_tvalid && s_tready)
    else $error("skid beat not drained");

endmodule

`default_nettype wire

// ===== hdl/bgcd_step.sv =====
// One registered step of the binary GCD pipeline: a common-factor shift, a
// swap to an odd a, a halving or a subtract-and-halve. Depends on bgcd_pkg.
`default_nettype none

module bgcd_step #(
  parameter int DATA_WIDTH = 32,
  parameter int TWOS_W     = 5
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire bgcd_pkg::ctl_t        ctl_in,
  input  wire logic [DATA_WIDTH-1:0] a_in,
  input  wire logic [DATA_WIDTH-1:0] b_in,
  input  wire logic [TWOS_W-1:0]     twos_in,
  output bgcd_pkg::ctl_t             ctl_out,
  output logic      [DATA_WIDTH-1:0] a_out,
  output logic      [DATA_WIDTH-1:0] b_out,
  output logic      [TWOS_W-1:0]     twos_out
);
  import bgcd_pkg::*;

  logic [DATA_WIDTH:0]   a_minus_b;
  logic [DATA_WIDTH-1:0] b_minus_a;
  logic                  a_lt_b;
  logic [DATA_WIDTH-1:0] a_next;
  logic [DATA_WIDTH-1:0] b_next;
  logic [TWOS_W-1:0]     twos_next;
  logic                  pre_next;

  assign a_minus_b = {1'b0, a_in} - {1'b0, b_in};
  assign b_minus_a = b_in - a_in;
  assign a_lt_b    = a_minus_b[DATA_WIDTH];

  always_comb begin
    a_next    = a_in;
    b_next    = b_in;
    twos_next = twos_in;
    pre_next  = ctl_in.pre;
    if (ctl_in.pre) begin
      if ((a_in[0] | b_in[0]) == 1'b0) begin
        a_next    = a_in >> 1;
        b_next    = b_in >> 1;
        twos_next = twos_in + TWOS_W'(1);
      end else begin
        // leave with an odd a; the divisor does not care about order
        pre_next = 1'b0;
        if (!a_in[0]) begin
          a_next = b_in;
          b_next = a_in;
        end
      end
    end else if (b_in != '0) begin
      if (!b_in[0]) begin
        b_next = b_in >> 1;
      end else if (a_lt_b) begin
        b_next = b_minus_a >> 1;
      end else begin
        a_next = b_in;
        b_next = a_minus_b[DATA_WIDTH-1:0] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
      ctl_out.pre   <= pre_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_out    <= a_next;
      b_out    <= b_next;
      twos_out <= twos_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bgcd_out.sv =====
// Final shift by the common power of two, output register and skid beat.
// Depends on bgcd_pkg.
`default_nettype none

module bgcd_out #(
  parameter int DATA_WIDTH = 32,
  parameter int TWOS_W     = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic [DATA_WIDTH-1:0]       a_in,
  input  wire logic [TWOS_W-1:0]           twos_in,
  output logic                             en,
  output logic                             skid_valid,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [bgcd_pkg::M_TDATA_W-1:0]   m_tdata    // [31:0] divisor
);
  import bgcd_pkg::*;

  logic [DATA_WIDTH-1:0]            shifted;
  logic [DATA_WIDTH+DIVISOR_W-1:0]  shifted_ext;
  logic [DIVISOR_W-1:0]             result;
  logic [DIVISOR_W-1:0]             skid_data;

  assign shifted     = a_in << twos_in;
  assign shifted_ext = {{DIVISOR_W{1'b0}}, shifted};
  assign result      = shifted_ext[DIVISOR_W-1:0];
  assign en          = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (m_tvalid && !m_tready) begin
        skid_valid <= 1'b1;
      end
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        m_tdata <= skid_data;
      end
    end else if (in_valid) begin
      // park the beat if the output is held
      if (m_tvalid && !m_tready) begin
        skid_data <= result;
      end else begin
        m_tdata <= result;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking bench for binary_gcd_top: directed and random operand pairs,
// each divisor checked against the table or a local Stein's-algorithm predictor.
// Depends on bgcd_pkg and the binary_gcd_top RTL.
`timescale 1ns / 100ps

module tb_top;
  import bgcd_pkg::*;

  localparam int NUM_DIRECTED = 22;
  localparam int NUM_RANDOM   = 1250;
  localparam int MID_PAUSE    = NUM_DIRECTED + 600;
  localparam int HOLD_AT      = NUM_DIRECTED + 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_FROM   = NUM_DIRECTED + 1000;
  localparam int SETTLE       = 2 * OPERAND_W + 16;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [OPERAND_W-1:0] a;
    logic [OPERAND_W-1:0] b;
    logic                 known;    // divisor column holds the answer
    logic [DIVISOR_W-1:0] divisor;
  } gcd_vec_t;

  typedef enum int {
    SHAPE_RANDOM, SHAPE_COMMON, SHAPE_POW2, SHAPE_ZERO, SHAPE_NEAR, SHAPE_ONEBIT, SHAPE_SMALL
  } shape_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;   // [31:0] operand_a, [63:32] operand_b
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;         // [31:0] divisor

  logic [DIVISOR_W-1:0] divisor_q [$];
  logic [DIVISOR_W-1:0] want_divisor;
  int                   pairs_sent   = 0;
  int                   divisors_in  = 0;
  int                   mismatches   = 0;
  int                   cycle_count  = 0;

  gcd_vec_t directed_tbl [NUM_DIRECTED] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0001},
    '{32'h8000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0001, 32'h0000_0001, 1'b1, 32'h0000_0001},
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0001},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{32'h8000_0000, 32'h0000_0001, 1'b1, 32'h0000_0001},
    '{32'h0000_0001, 32'h8000_0000, 1'b1, 32'h0000_0001},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, 32'h0000_0001},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
    '{32'h8000_0000, 32'h4000_0000, 1'b1, 32'h4000_0000},
    '{32'h0000_000C, 32'h0000_0012, 1'b1, 32'h0000_0006},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'h5555_5555},
    '{32'hB504_F333, 32'h9E37_79B9, 1'b0, 32'h0000_0000},
    '{32'hFFFF_FFFB, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{32'h0000_FF00, 32'h00FF_0000, 1'b0, 32'h0000_0000},
    // consecutive Fibonacci numbers: longest subtract chain
    '{32'hB119_24E1, 32'h6D73_E55F, 1'b0, 32'h0000_0000},
    '{32'hFFFF_FFFE, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000}
  };

  binary_gcd_top #(
    .DATA_WIDTH(OPERAND_W)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [DIVISOR_W-1:0] stein_gcd(input logic [OPERAND_W-1:0] a,
                                                     input logic [OPERAND_W-1:0] b);
    logic [OPERAND_W-1:0] x;
    logic [OPERAND_W-1:0] y;
    logic [OPERAND_W-1:0] diff;
    int unsigned          twos;
    x    = a;
    y    = b;
    twos = 0;
    if (x == '0 || y == '0) return x | y;
    // strip the shared power of two
    while (x[0] == 1'b0 && y[0] == 1'b0) begin
      x = x >> 1;
      y = y >> 1;
      twos++;
    end
    while (x[0] == 1'b0) x = x >> 1;
    do begin
      while (y[0] == 1'b0) y = y >> 1;
      if (x < y) begin
        y = y - x;
      end else begin
        diff = x - y;
        x    = y;
        y    = diff;
      end
      y = y >> 1;
    end while (y != '0);
    return x << twos;
  endfunction

  // Offer one pair, hold it until taken, then queue its divisor
  task automatic send_pair(input logic [OPERAND_W-1:0] a, input logic [OPERAND_W-1:0] b,
                           input logic known, input logic [DIVISOR_W-1:0] divisor);
    logic [DIVISOR_W-1:0] queued;
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    do @(posedge clk); while (!s_tready);
    queued    = known ? divisor : stein_gcd(a, b);
    divisor_q = {divisor_q, queued};
    pairs_sent <= pairs_sent + 1;
    if (pairs_sent < QUIET_FROM && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain_divisors();
    s_tvalid <= 1'b0;
    while (divisor_q.size() != 0) @(posedge clk);
  endtask

  initial begin : reset_gen
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d divisors outstanding", $time, divisor_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      divisors_in <= divisors_in + 1;
      if (divisor_q.size() == 0) begin
        mismatches++;
        $display("%0t: divisor beat with none expected: expected none, actual %h",
                 $time, m_tdata);
      end else begin
        want_divisor = divisor_q.pop_front();
        if (m_tdata !== want_divisor) begin
          mismatches++;
          $display("%0t: divisor mismatch: expected %h, actual %h",
                   $time, want_divisor, m_tdata);
        end
      end
    end
  end

  // Master-side back-pressure: random bursts, one long hold-off, none at the end
  initial begin : ready_driver
    int unsigned held_cycles;
    bit          held_off;
    held_off = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!held_off && pairs_sent >= HOLD_AT) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        held_cycles = 0;
        while (held_cycles < HOLD_CYCLES) begin
          @(posedge clk);
          held_cycles++;
        end
        m_tready <= 1'b1;
      end else if (pairs_sent < QUIET_FROM && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [OPERAND_W-1:0] op_a;
    logic [OPERAND_W-1:0] op_b;
    logic [OPERAND_W-1:0] factor;
    int unsigned          k;
    shape_t               shape;

    wait (!rst);
    @(posedge clk);

    foreach (directed_tbl[i])
      send_pair(directed_tbl[i].a, directed_tbl[i].b, directed_tbl[i].known,
                directed_tbl[i].divisor);
    drain_divisors();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n + NUM_DIRECTED == MID_PAUSE) drain_divisors();
      shape = shape_t'($urandom_range(SHAPE_RANDOM, SHAPE_SMALL));
      op_a  = $urandom;
      op_b  = $urandom;
      case (shape)
        SHAPE_COMMON: begin
          factor = $urandom_range(1, 65535);
          op_a   = factor * $urandom_range(0, 65535);
          op_b   = factor * $urandom_range(0, 65535);
        end
        SHAPE_POW2: begin
          k    = $urandom_range(0, OPERAND_W - 1);
          op_a = op_a << k;
          op_b = op_b << k;
        end
        SHAPE_ZERO: begin
          // either side zero, now and then both
          if ($urandom_range(0, 1)) op_a = '0;
          else op_b = '0;
          if ($urandom_range(0, 7) == 0) op_b = '0;
        end
        SHAPE_NEAR: begin
          op_b = $urandom_range(0, 1) ? op_a : op_a + 1'b1;
        end
        SHAPE_ONEBIT: begin
          op_a = '1 << $urandom_range(0, OPERAND_W - 1);
          op_a = op_a & ~(op_a << 1);
          if ($urandom_range(0, 3) == 0) op_b = '1;
        end
        SHAPE_SMALL: begin
          op_a = $urandom_range(0, 255);
          op_b = $urandom_range(0, 255);
        end
        default: ;
      endcase
      if ($urandom_range(0, 1)) {op_a, op_b} = {op_b, op_a};
      send_pair(op_a, op_b, 1'b0, '0);
    end

    drain_divisors();
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d operand pairs (%0d from the directed table), checked %0d divisors.",
             pairs_sent, NUM_DIRECTED, divisors_in);
    $display("Covered zero operands, shared powers of two and common factors, under random"
             , " stalls and a %0d-cycle output hold-off.", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
